>>> design/fpaf_pkg.sv
// shared types, constants and helper functions of the fixed-point to ascii formatter
// no dependencies; used by every module of the block
package fpaf_pkg;

	localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

	// configuration register indexes
	localparam logic REG_FRACTION_BITS  = 1'b0;
	localparam logic REG_INTEGER_DIGITS = 1'b1;

	localparam logic [3:0] FRAC_BITS_MAX  = 4'd12;
	localparam logic [3:0] TRAIL_ZERO_MIN = 4'd5;
	localparam logic [2:0] INT_DIGITS_MIN = 3'd1;
	localparam logic [2:0] INT_DIGITS_MAX = 3'd5;
	localparam logic [2:0] INT_DIGITS_RST = 3'd5;

	// conversion sequencer: four dabble steps a cycle
	localparam logic [3:0] CNT_INT_LAST  = 4'd3;
	localparam logic [3:0] CNT_SUM_LAST  = 4'd2;
	localparam logic [3:0] CNT_FRAC_LOAD = 4'd3;
	localparam logic [3:0] CNT_DONE      = 4'd8;

	// character codes
	localparam logic [5:0] CH_SPACE = 6'h20;
	localparam logic [5:0] CH_MINUS = 6'h2D;
	localparam logic [5:0] CH_POINT = 6'h2E;
	localparam logic [5:0] CH_ZERO  = 6'h30;

	// one converted value on its way to the character sequencer
	typedef struct packed {
		logic            neg;
		logic [2:0]      ndig;
		logic            trail;
		logic [4:0][3:0] idig;
		logic [3:0][3:0] fdig;
	} fmt_rec_t;

	// weight of fraction bit k below the point, scaled by 40000
	function automatic logic [14:0] frac_weight(input logic [3:0] k);
		logic [14:0] w;
		case (k)
			4'd0:    w = 15'd20000;
			4'd1:    w = 15'd10000;
			4'd2:    w = 15'd5000;
			4'd3:    w = 15'd2500;
			4'd4:    w = 15'd1250;
			4'd5:    w = 15'd625;
			4'd6:    w = 15'd312;
			4'd7:    w = 15'd156;
			4'd8:    w = 15'd78;
			4'd9:    w = 15'd39;
			4'd10:   w = 15'd19;
			4'd11:   w = 15'd9;
			default: w = 15'd0;
		endcase
		return w;
	endfunction

	// one double dabble step on five bcd digits
	function automatic logic [19:0] dd_step(input logic [19:0] acc, input logic b);
		logic [19:0] a;
		a = acc;
		for (int n = 0; n < 5; n++) begin
			if (a[4*n +: 4] >= 4'd5) begin
				a[4*n +: 4] = a[4*n +: 4] + 4'd3;
			end
		end
		return {a[18:0], b};
	endfunction

	// four steps, msb first
	function automatic logic [19:0] dd_step4(input logic [19:0] acc, input logic [3:0] bits);
		logic [19:0] a;
		a = acc;
		for (int j = 3; j >= 0; j--) begin
			a = dd_step(a, bits[j]);
		end
		return a;
	endfunction

endpackage

>>> design/fpaf_front.sv
// front end: configuration registers, input acceptance and the bcd conversion unit
// depends on fpaf_pkg
module fpaf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [3:0]        wr_data,
	input  logic              push,
	output logic              full,
	input  logic signed [15:0] value,
	output logic              rec_push,
	output fpaf_pkg::fmt_rec_t rec,
	input  logic              rec_full
);
	import fpaf_pkg::*;

	logic [3:0]  frac_bits_q;
	logic [2:0]  int_digits_q;

	logic        busy_q;
	logic [3:0]  cnt_q;
	logic        neg_q;
	logic [2:0]  ndig_q;
	logic        trail_q;
	logic [15:0] ibin_q;
	logic [19:0] iacc_q;
	logic [11:0] fsh_q;
	logic [15:0] sum_q;
	logic [15:0] fbin_q;
	logic [19:0] facc_q;

	logic        accept;
	logic        neg;
	logic [15:0] negval;
	logic [14:0] mag;
	logic [3:0]  fb;
	logic [2:0]  nd;
	logic [31:0] fr_wide;
	logic [15:0] sum_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_bits_q  <= '0;
			int_digits_q <= INT_DIGITS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_FRACTION_BITS:  frac_bits_q  <= wr_data;
				REG_INTEGER_DIGITS: int_digits_q <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	assign rec_push = busy_q && (cnt_q == CNT_DONE) && !rec_full;
	assign full     = busy_q && !rec_push;
	assign accept   = push && !full;

	always_comb begin
		neg    = value[15];
		negval = 16'(-value);
		if (!neg) begin
			mag = value[14:0];
		end else if (negval[15]) begin
			// most negative input saturates
			mag = 15'h7FFF;
		end else begin
			mag = negval[14:0];
		end
		fb = (frac_bits_q > FRAC_BITS_MAX) ? FRAC_BITS_MAX : frac_bits_q;
		if (int_digits_q < INT_DIGITS_MIN) begin
			nd = INT_DIGITS_MIN;
		end else if (int_digits_q > INT_DIGITS_MAX) begin
			nd = INT_DIGITS_MAX;
		end else begin
			nd = int_digits_q;
		end
		// fraction bits aligned under the point
		fr_wide = {1'b0, mag, 16'h0000} >> fb;
	end

	always_comb begin
		sum_add = sum_q;
		for (int j = 0; j < 4; j++) begin
			if (fsh_q[11 - j]) begin
				sum_add = sum_add + 16'(frac_weight({cnt_q[1:0], 2'(j)}));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (rec_push) begin
			busy_q <= 1'b0;
		end else if (busy_q && cnt_q != CNT_DONE) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= neg;
			ndig_q  <= nd;
			trail_q <= (fb > TRAIL_ZERO_MIN);
			ibin_q  <= {1'b0, mag >> fb};
			iacc_q  <= '0;
			fsh_q   <= fr_wide[15:4];
			sum_q   <= '0;
		end else if (busy_q) begin
			if (cnt_q <= CNT_INT_LAST) begin
				iacc_q <= dd_step4(iacc_q, ibin_q[15:12]);
				ibin_q <= {ibin_q[11:0], 4'h0};
			end
			if (cnt_q <= CNT_SUM_LAST) begin
				sum_q <= sum_add;
				fsh_q <= {fsh_q[7:0], 4'h0};
			end
			if (cnt_q == CNT_FRAC_LOAD) begin
				fbin_q <= {2'b00, sum_q[15:2]};
				facc_q <= '0;
			end else if (cnt_q > CNT_FRAC_LOAD && cnt_q != CNT_DONE) begin
				facc_q <= dd_step4(facc_q, fbin_q[15:12]);
				fbin_q <= {fbin_q[11:0], 4'h0};
			end
		end
	end

	always_comb begin
		rec.neg   = neg_q;
		rec.ndig  = ndig_q;
		rec.trail = trail_q;
		rec.idig  = iacc_q;
		rec.fdig  = facc_q[15:0];
	end

endmodule

>>> design/fpaf_queue.sv
// short record queue between the conversion front end and the character sequencer
// depends on fpaf_pkg
module fpaf_queue #(
	parameter int unsigned DEPTH = fpaf_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  fpaf_pkg::fmt_rec_t wdata,
	output logic               qfull,
	input  logic               rd,
	output logic               qvalid,
	output fpaf_pkg::fmt_rec_t rdata
);
	import fpaf_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	fmt_rec_t        mem_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;

	assign qfull  = (count_q == CW'(DEPTH));
	assign qvalid = (count_q != '0);
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> design/fpaf_back.sv
// back end: walks one record character by character into the output register
// depends on fpaf_pkg
module fpaf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               qvalid,
	input  fpaf_pkg::fmt_rec_t rec,
	output logic               rd,
	output logic               empty,
	input  logic               pop,
	output logic [5:0]         character,
	output logic               last_char
);
	import fpaf_pkg::*;

	typedef enum logic [4:0] {
		ST_SIGN  = 5'b00001,
		ST_INT   = 5'b00010,
		ST_POINT = 5'b00100,
		ST_FRAC  = 5'b01000,
		ST_TRAIL = 5'b10000
	} seq_state_t;

	seq_state_t  state_q;
	seq_state_t  state_d;
	logic [2:0]  dig_q;
	logic [2:0]  dig_d;
	logic        blank_q;
	logic        blank_d;
	logic        ovalid_q;
	logic [5:0]  char_q;
	logic        last_q;

	logic        advance;
	logic [5:0]  ch;
	logic        lst;
	logic [2:0]  idx;
	logic [3:0]  nib;
	logic        blanking;

	assign advance   = qvalid && (!ovalid_q || pop);
	assign empty     = !ovalid_q;
	assign character = char_q;
	assign last_char = last_q;

	always_comb begin
		state_d  = state_q;
		dig_d    = dig_q;
		blank_d  = blank_q;
		ch       = CH_ZERO;
		lst      = 1'b0;
		rd       = 1'b0;
		idx      = (state_q == ST_SIGN) ? rec.ndig - 3'd1 : dig_q;
		nib      = rec.idig[idx];
		blanking = (state_q == ST_SIGN) ? 1'b1 : blank_q;
		case (state_q)
			ST_SIGN, ST_INT: begin
				if (state_q == ST_SIGN && rec.neg) begin
					ch      = CH_MINUS;
					state_d = ST_INT;
					dig_d   = rec.ndig - 3'd1;
					blank_d = 1'b1;
				end else begin
					// leading zeros become spaces, the ones digit never does
					if (blanking && nib == 4'h0 && idx != 3'd0) begin
						ch      = CH_SPACE;
						blank_d = 1'b1;
					end else begin
						ch      = CH_ZERO | {2'b00, nib};
						blank_d = 1'b0;
					end
					state_d = (idx == 3'd0) ? ST_POINT : ST_INT;
					dig_d   = idx - 3'd1;
				end
			end
			ST_POINT: begin
				ch      = CH_POINT;
				state_d = ST_FRAC;
				dig_d   = 3'd3;
			end
			ST_FRAC: begin
				ch    = CH_ZERO | {2'b00, rec.fdig[dig_q[1:0]]};
				dig_d = dig_q - 3'd1;
				if (dig_q == 3'd0) begin
					if (rec.trail) begin
						state_d = ST_TRAIL;
					end else begin
						lst     = 1'b1;
						state_d = ST_SIGN;
					end
				end
			end
			ST_TRAIL: begin
				ch      = CH_ZERO;
				lst     = 1'b1;
				state_d = ST_SIGN;
			end
			default: begin
				state_d = ST_SIGN;
			end
		endcase
		if (!advance) begin
			state_d = state_q;
			dig_d   = dig_q;
			blank_d = blank_q;
		end else begin
			rd = lst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SIGN;
			dig_q    <= '0;
			blank_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dig_q   <= dig_d;
			blank_q <= blank_d;
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_q <= ch;
			last_q <= lst;
		end
	end

endmodule

>>> design/fixed_point_to_ascii_formatter_top.sv
// top level of the fixed-point to ascii formatter
// depends on fpaf_pkg, fpaf_front, fpaf_queue and fpaf_back

// Each signed 16-bit value pushed in comes out as its decimal text, one ASCII word per
// pop: an optional '-', integer_digits integer digits (leading zeros shown as spaces),
// '.', four fraction digits, and a trailing '0' when fraction_bits is above five;
// last_char marks the final word of a string. The front end runs four double dabble
// steps a cycle for the integer part, with the fraction sum alongside, then converts
// the fraction, and takes the next value in the cycle it hands one over. The sequencer
// emits one word a cycle while words are popped and a record waits, 6 to 12 per value.
// The user must write configuration only while no string is in flight; the block
// itself does not enforce this.
module fixed_point_to_ascii_formatter_top #(
	parameter int unsigned QUEUE_DEPTH = fpaf_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [3:0]         wr_data,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] value,
	output logic               empty,
	input  logic               pop,
	output logic [5:0]         character,
	output logic               last_char
);
	import fpaf_pkg::*;

	logic     rec_push;
	logic     rec_full;
	logic     rec_rd;
	logic     rec_valid;
	fmt_rec_t rec_in;
	fmt_rec_t rec_out;

	fpaf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.full     (full),
		.value    (value),
		.rec_push (rec_push),
		.rec      (rec_in),
		.rec_full (rec_full)
	);

	fpaf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rec_push),
		.wdata  (rec_in),
		.qfull  (rec_full),
		.rd     (rec_rd),
		.qvalid (rec_valid),
		.rdata  (rec_out)
	);

	fpaf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qvalid    (rec_valid),
		.rec       (rec_out),
		.rd        (rec_rd),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.last_char (last_char)
	);

endmodule
